### sv/tli_pkg.sv
// Shared types and constants for the table linear interpolator.
// No dependencies; imported by tli_div and table_linear_interpolator_core.
package tli_pkg;

	// Field widths fixed by the item format
	localparam int COORD_W   = 16;
	localparam int COUNT_W   = 5;
	localparam int INDEX_W   = 4;
	localparam int S_TDATA_W = 56;
	localparam int PROD_W    = 2 * COORD_W;

	// Operation codes carried in tuser
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// One table entry as stored in the breakpoint memory
	typedef struct packed {
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} tli_entry_t;

	// Divider request and response
	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0]  dividend;
		logic [COORD_W-1:0] divisor;
	} tli_div_req_t;

	typedef struct packed {
		logic               done;
		logic [COORD_W-1:0] quotient;
	} tli_div_rsp_t;

endpackage

### sv/tli_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/tli_div.sv
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
// Depends on tli_pkg. The caller guarantees dividend[31:16] < divisor.
module tli_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tli_pkg::tli_div_req_t req,
	output tli_pkg::tli_div_rsp_t rsp
);
	import tli_pkg::*;

	localparam int CNT_W = $clog2(COORD_W);

	logic [COORD_W-1:0] rem_q;
	logic [COORD_W-1:0] quo_q;
	logic [COORD_W-1:0] den_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [COORD_W:0]   trial;
	logic               fits;
	logic [COORD_W-1:0] rem_nxt;

	// Trial subtract of the shifted partial remainder
	always_comb begin
		trial   = {rem_q, quo_q[COORD_W-1]};
		fits    = trial >= {1'b0, den_q};
		rem_nxt = fits ? COORD_W'(trial - {1'b0, den_q}) : COORD_W'(trial);
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(COORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend[PROD_W-1:COORD_W];
			quo_q <= req.dividend[COORD_W-1:0];
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[COORD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

### sv/table_linear_interpolator_core.sv
// Piecewise-linear table interpolator, top level.
// Depends on tli_pkg, tli_ram and tli_div.
//
// Usage:
//   s_axis carries items: tuser = operation (0 write a breakpoint, 1 query).
//   A write stores (point_x, point_y) at point_index and gives
//   no result; an index at or above MAX_POINTS is dropped. A query scans the
//   breakpoint memory and returns one interpolated value on m_axis.
//   cfg_wen/cfg_wdata set the number of breakpoints in use (reset 16);
//   write it only while no query is in flight.
// Operation:
//   One item at a time. A query reads the first and last entries to pick the
//   scan direction, scans one breakpoint at a time and, inside a segment, takes
//   a multiply step and the divider's 16 steps, then loads the output register;
//   the single memory read port and the bit-serial divider pace it.
// Reset and stall:
//   Reset clears control state and sets the count to 16; table contents stay
//   undefined until written. A stalled receiver holds the result in the output
//   register; input is still taken, and a new query waits at its end until
//   the output register frees up.
module table_linear_interpolator_core #(
	parameter int MAX_POINTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [3:0] point_index, [19:4] point_x, [35:20] point_y, [51:36] target, zero fill
	input  logic [55:0] s_axis_tdata,
	// [0] operation
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] interpolated
	output logic [15:0] m_axis_tdata,
	input  logic        cfg_wen,
	input  logic [4:0]  cfg_wdata
);
	import tli_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FIRST = 3'd1;
	localparam logic [2:0] ST_LAST  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]         state_q;
	logic [COUNT_W-1:0] point_count_q;
	logic               out_valid_q;
	logic [COORD_W-1:0] out_data_q;

	logic [COORD_W-1:0] t_q;
	tli_entry_t         first_q;
	logic [COORD_W-1:0] x0_q;
	logic [COORD_W-1:0] y0_q;
	logic [AW-1:0]      cur_idx_q;
	logic [AW-1:0]      k_q;
	logic               dir_q;
	logic [COORD_W-1:0] den_q;
	logic [COORD_W-1:0] dx_q;
	logic [COORD_W-1:0] mag_q;
	logic               neg_q;
	logic [COORD_W-1:0] res_q;

	// Input field unpacking
	logic [INDEX_W-1:0] in_index;
	logic [COORD_W-1:0] in_x;
	logic [COORD_W-1:0] in_y;
	logic [COORD_W-1:0] in_target;
	logic               in_accept;

	assign in_index  = s_axis_tdata[3:0];
	assign in_x      = s_axis_tdata[19:4];
	assign in_y      = s_axis_tdata[35:20];
	assign in_target = s_axis_tdata[51:36];
	assign in_accept = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = (state_q == ST_IDLE);

	// Last index in use, count clamped to 1..MAX_POINTS
	logic [AW-1:0] last_idx;
	always_comb begin
		if (point_count_q == '0) begin
			last_idx = '0;
		end else if (32'(point_count_q) > MAX_POINTS) begin
			last_idx = AW'(MAX_POINTS - 1);
		end else begin
			last_idx = AW'(point_count_q - 5'd1);
		end
	end

	// Breakpoint memory
	logic          mem_we;
	logic [AW-1:0] mem_raddr;
	tli_entry_t    mem_wdata;
	tli_entry_t    rd;

	assign mem_we    = in_accept && (s_axis_tuser == OP_WRITE) && (32'(in_index) < MAX_POINTS);
	assign mem_wdata = '{y: in_y, x: in_x};

	tli_ram #(
		.WIDTH($bits(tli_entry_t)),
		.DEPTH(MAX_POINTS)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(AW'(in_index)),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rd)
	);

	// Scan stepping and segment terms
	logic               dir_now;
	logic [AW-1:0]      start_idx;
	logic [AW-1:0]      nxt_idx;
	logic [COORD_W-1:0] dy;
	logic               is_below;
	logic               scan_end;

	assign dir_now   = first_q.x > rd.x;
	assign start_idx = dir_now ? last_idx : '0;
	assign nxt_idx   = dir_q ? cur_idx_q - 1'b1 : cur_idx_q + 1'b1;
	assign dy        = rd.y - y0_q;
	assign is_below  = rd.x < t_q;
	assign scan_end  = (k_q == last_idx);

	// Read address selection
	always_comb begin
		unique case (state_q)
			ST_FIRST: mem_raddr = last_idx;
			ST_LAST:  mem_raddr = start_idx;
			ST_SCAN:  mem_raddr = scan_end ? cur_idx_q : nxt_idx;
			default:  mem_raddr = '0;
		endcase
	end

	// Divider
	tli_div_req_t div_req;
	tli_div_rsp_t div_rsp;
	logic [COORD_W-1:0] q_signed;

	assign div_req.start    = (state_q == ST_MUL);
	assign div_req.dividend = mag_q * dx_q;
	assign div_req.divisor  = den_q;
	assign q_signed         = neg_q ? COORD_W'(-div_rsp.quotient) : div_rsp.quotient;

	tli_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	logic out_free;
	assign out_free = !out_valid_q || m_axis_tready;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			point_count_q <= 5'd16;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wen) begin
				point_count_q <= cfg_wdata;
			end
			// Output valid: set on a result load, cleared when the item is taken
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && s_axis_tuser == OP_QUERY) begin
						state_q <= ST_FIRST;
					end
				end
				ST_FIRST: state_q <= ST_LAST;
				ST_LAST:  state_q <= ST_SCAN;
				ST_SCAN: begin
					priority if (is_below) begin
						if (scan_end) begin
							state_q <= ST_DONE;
						end
					end else if (rd.x == x0_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				t_q <= in_target;
			end
			ST_FIRST: begin
				first_q <= rd;
			end
			ST_LAST: begin
				dir_q     <= dir_now;
				x0_q      <= dir_now ? rd.x : first_q.x;
				y0_q      <= dir_now ? rd.y : first_q.y;
				cur_idx_q <= start_idx;
				k_q       <= '0;
			end
			ST_SCAN: begin
				cur_idx_q <= nxt_idx;
				k_q       <= k_q + 1'b1;
				if (is_below) begin
					x0_q  <= rd.x;
					y0_q  <= rd.y;
					res_q <= rd.y;
				end else begin
					res_q <= rd.y;
					den_q <= rd.x - x0_q;
					dx_q  <= t_q - x0_q;
					neg_q <= dy[COORD_W-1];
					mag_q <= dy[COORD_W-1] ? COORD_W'(-dy) : dy;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					res_q <= y0_q + q_signed;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_data_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// The divider only finishes while the sequencer waits on it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider done outside of divide state");

	// Scan count never passes the last entry in use
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> k_q <= last_idx)
		else $error("scan ran past the last breakpoint");

	// A segment sent to the divider always has a nonzero width
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> den_q != '0)
		else $error("zero-width segment reached the divider");

	// A finished query never overwrites a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !m_axis_tready) |=> state_q == ST_DONE)
		else $error("result register overwritten while stalled");

endmodule

### test/table_linear_interpolator_core_test.sv
`timescale 1ns / 100ps
// Testbench for table_linear_interpolator_core: breakpoint writes, interpolation
// queries and point-count settings. Depends on tli_pkg and the core RTL only.
module table_linear_interpolator_core_test;
	import tli_pkg::*;

	localparam int NUM_POINTS    = 16;
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int ITEM_GOAL     = 1700;
	localparam int MAX_REPORTS   = 100;

	// Shapes of breakpoint tables loaded during random traffic
	typedef enum int {
		TABLE_RISING,
		TABLE_FALLING,
		TABLE_SCATTER,
		TABLE_STEPPED
	} table_shape_t;

	// One outstanding query: its target and the value it must return
	typedef struct {
		logic [COORD_W-1:0] target;
		logic [COORD_W-1:0] interp;
	} pending_query_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	// [3:0] point_index, [19:4] point_x, [35:20] point_y, [51:36] target, zero fill
	logic [55:0]        s_axis_tdata;
	// [0] operation
	logic               s_axis_tuser;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	// [15:0] interpolated
	logic [15:0]        m_axis_tdata;
	logic               cfg_wen;
	logic [COUNT_W-1:0] cfg_wdata;

	// Predictor state: shadow of the breakpoint table and point count
	logic [COORD_W-1:0] x_table [NUM_POINTS];
	logic [COORD_W-1:0] y_table [NUM_POINTS];
	logic [COUNT_W-1:0] point_count_q = 5'd16;

	pending_query_t     pending_interp [$];
	int                 fail_count  = 0;
	int                 sent_items  = 0;
	int                 cycle_count = 0;

	// Idling controls shared by the sender and the receiver
	bit                 tx_idling   = 1'b0;
	bit                 rx_stalls   = 1'b0;
	bit                 hold_request = 1'b0;
	int                 hold_cycles = 0;
	int                 hold_left   = 0;
	int                 stall_left  = 0;

	table_linear_interpolator_core #(
		.MAX_POINTS(NUM_POINTS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_interp.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Gap length: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Receiver: long hold-off on request, otherwise random stalls when enabled
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_stalls && stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
			stall_left = pick_gap() - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Result checker: each output item against the oldest pending query
	always @(posedge clk) begin
		pending_query_t head;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_interp.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual %h",
						$time, m_axis_tdata);
			end else begin
				head = pending_interp.pop_front();
				if (m_axis_tdata !== head.interp) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: interpolated for target %h: expected %h, actual %h",
							$time, head.target, head.interp, m_axis_tdata);
				end
			end
		end
	end

	// Breakpoints in use, with the out-of-range counts folded in
	function automatic int points_in_use();
		if (point_count_q == 0)
			return 1;
		if (point_count_q > NUM_POINTS)
			return NUM_POINTS;
		return int'(point_count_q);
	endfunction

	// Scan the shadow table and interpolate at tgt
	function automatic logic [COORD_W-1:0] predict_interp(input logic [COORD_W-1:0] tgt);
		int n;
		int idx;
		int stride;
		logic [COORD_W-1:0] x0, y0, x1, y1, dy;
		longint num;
		longint quo;
		n = points_in_use();
		idx = 0;
		stride = 1;
		if (x_table[0] > x_table[n-1]) begin
			idx = n - 1;
			stride = -1;
		end
		x0 = x_table[idx];
		y0 = y_table[idx];
		x1 = '0;
		y1 = '0;
		for (int k = 0; k < n; k++) begin
			x1 = x_table[idx];
			y1 = y_table[idx];
			if (x1 < tgt) begin
				x0 = x1;
				y0 = y1;
			end else begin
				// equal x (first entry) returns y as is
				if (x1 > x0) begin
					dy = y1 - y0;
					num = longint'($signed(dy)) * (longint'(tgt) - longint'(x0));
					quo = num / (longint'(x1) - longint'(x0));
					y1 = 16'(quo + longint'(y0));
				end
				break;
			end
			idx += stride;
			if (idx < 0 || idx >= NUM_POINTS)
				break;
		end
		return y1;
	endfunction

	// Offer one item, wait for the handshake, update the predictor, maybe idle
	task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
		input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
		input logic [COORD_W-1:0] tgt);
		pending_query_t q;
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {4'b0, tgt, py, px, idx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent_items++;
		if (op == OP_QUERY) begin
			q.target = tgt;
			q.interp = predict_interp(tgt);
			pending_interp.push_back(q);
		end else begin
			x_table[idx] = px;
			y_table[idx] = py;
		end
		gap = (tx_idling && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_point(input logic [INDEX_W-1:0] idx, input logic [COORD_W-1:0] px,
		input logic [COORD_W-1:0] py);
		send_item(OP_WRITE, idx, px, py, 16'($urandom));
	endtask

	task automatic query_at(input logic [COORD_W-1:0] tgt);
		send_item(OP_QUERY, 4'($urandom), 16'($urandom), 16'($urandom), tgt);
	endtask

	// Stop offering, wait for all results, then let the core go quiet
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_interp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_point_count(input logic [COUNT_W-1:0] value);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		point_count_q = value;
		cfg_wen   <= 1'b0;
		cfg_wdata <= 5'($urandom);
		@(posedge clk);
	endtask

	// Targets: ends of the range, on a breakpoint, next to one, inside a segment, or random
	function automatic logic [COORD_W-1:0] pick_target();
		int n;
		int i;
		int lo;
		int hi;
		n = points_in_use();
		i = $urandom_range(0, n - 1);
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return x_table[i];
			4: return x_table[i] + 16'd1;
			5: return x_table[i] - 16'd1;
			6, 7: begin
				if (n < 2)
					return x_table[0];
				i = $urandom_range(0, n - 2);
				lo = (x_table[i] < x_table[i+1]) ? int'(x_table[i]) : int'(x_table[i+1]);
				hi = (x_table[i] < x_table[i+1]) ? int'(x_table[i+1]) : int'(x_table[i]);
				return 16'($urandom_range(lo, hi));
			end
			default: return 16'($urandom);
		endcase
	endfunction

	// Load all sixteen breakpoints with the given shape
	task automatic load_table(input table_shape_t shape);
		int acc;
		int step_max;
		logic [COORD_W-1:0] xs [NUM_POINTS];
		case ($urandom_range(0, 3))
			0: step_max = 1;
			1: step_max = 64;
			2: step_max = 2048;
			default: step_max = 8191;
		endcase
		acc = $urandom_range(0, 30000);
		for (int i = 0; i < NUM_POINTS; i++) begin
			if (shape == TABLE_SCATTER)
				xs[i] = 16'($urandom);
			else
				xs[i] = (acc > 65535) ? 16'hFFFF : 16'(acc);
			if (shape == TABLE_STEPPED && $urandom_range(0, 1) == 0)
				acc += 0;
			else
				acc += $urandom_range(0, step_max);
		end
		for (int i = 0; i < NUM_POINTS; i++)
			write_point(4'(i), (shape == TABLE_FALLING) ? xs[NUM_POINTS-1-i] : xs[i],
				16'($urandom));
	endtask

	// Fixed table over the full x range with extreme y steps and one zero-width segment
	task automatic test_directed_table();
		logic [COORD_W-1:0] ys [NUM_POINTS];
		ys = '{16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE, 16'h1234,
			16'hEDCB, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hAAAA, 16'h5555,
			16'h0F0F, 16'hF0F0};
		for (int i = 0; i < NUM_POINTS; i++)
			write_point(4'(i), (i == 8) ? 16'(7 * 4369) : 16'(i * 4369), ys[i]);
		query_at(16'h0000);         // first entry, returned as is
		query_at(16'hFFFF);         // last entry
		query_at(16'd4369);         // exactly on a breakpoint
		query_at(16'd2000);         // inside the first segment
		query_at(16'd1);
		query_at(16'(7 * 4369));    // on the doubled breakpoint
		query_at(16'(7 * 4369 + 1)); // just past the zero-width segment
		query_at(16'd40000);
		wait_idle();
	endtask

	// Point count at its extremes, including the out-of-range values
	task automatic test_count_extremes();
		logic [COUNT_W-1:0] counts [6];
		counts = '{5'd1, 5'd0, 5'd2, 5'd31, 5'd17, 5'd16};
		foreach (counts[c]) begin
			set_point_count(counts[c]);
			query_at(16'h0000);
			query_at(16'hFFFF);
			query_at(pick_target());
			wait_idle();
		end
	endtask

	// Receiver holds off long while the sender keeps offering
	task automatic test_backpressure();
		tx_idling = 1'b0;
		rx_stalls = 1'b0;
		hold_cycles = 400;
		hold_request = 1'b1;
		for (int i = 0; i < 14; i++) begin
			if (i % 4 == 3)
				write_point(4'($urandom), 16'($urandom), 16'($urandom));
			else
				query_at(pick_target());
		end
		wait_idle();
	endtask

	// Phases of random traffic, each with its own count and idling, mostly with a new table
	task automatic test_random_traffic();
		int r;
		while (sent_items < ITEM_GOAL) begin
			r = $urandom_range(0, 9);
			case (r)
				0: set_point_count(5'd0);
				1: set_point_count(5'($urandom_range(17, 31)));
				2: set_point_count(5'd16);
				3: set_point_count(5'd1);
				default: set_point_count(5'($urandom_range(2, 16)));
			endcase
			tx_idling = ($urandom_range(0, 3) != 0);
			rx_stalls = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 3) != 0)
				load_table(table_shape_t'($urandom_range(0, 3)));
			for (int i = 0; i < 40; i++) begin
				if ($urandom_range(0, 9) == 0)
					write_point(4'($urandom), 16'($urandom), 16'($urandom));
				else
					query_at(pick_target());
			end
			wait_idle();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_WRITE;
		m_axis_tready = 1'b0;
		cfg_wen       = 1'b0;
		cfg_wdata     = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_table();
		test_count_extremes();
		test_backpressure();
		test_random_traffic();

		wait_idle();
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
sv/tli_pkg.sv
sv/tli_ram.sv
sv/tli_div.sv
sv/table_linear_interpolator_core.sv
test/table_linear_interpolator_core_test.sv
